/* src/aiff_pcm_sample_unpacker_assert.svh */
// Assertion macros used by the checker module of the sample unpacker.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef AIFF_PCM_SAMPLE_UNPACKER_ASSERT_SVH
`define AIFF_PCM_SAMPLE_UNPACKER_ASSERT_SVH

// Same-cycle implication. It is disabled while reset is active.
`define APSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication. It is disabled while reset is active.
`define APSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks a condition in the cycle after reset is seen active.
`define APSU_ASSERT_AFTER_RST(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* src/apsu_pkg.sv */
package apsu_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd1;

  // Sample formats. The remaining code is unsupported.
  typedef enum logic [1:0] {
    FMT_BIG    = 2'd0,
    FMT_LITTLE = 2'd1,
    FMT_FLOAT  = 2'd2
  } apsu_fmt_e;

  // Sample widths, coded as bytes per sample minus one.
  typedef enum logic [1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_24 = 2'd2,
    WID_32 = 2'd3
  } apsu_wid_e;

  // Constants of the integer and float decode paths.
  localparam logic [7:0]  FLIP_MASK      = 8'h80;
  localparam logic [14:0] FLOAT_SCALE    = 15'd32767;
  localparam logic [7:0]  EXP_SHIFT_BASE = 8'd136;
  localparam logic [7:0]  EXP_MIN_LIVE   = 8'd111;
  localparam logic [7:0]  EXP_SAT        = 8'd128;
  localparam logic [7:0]  EXP_SPECIAL    = 8'hFF;
  localparam logic [15:0] MAG_SAT        = 16'd32768;
  localparam logic [15:0] POS_MAX        = 16'h7FFF;

  // One completed sample on its way from the gather stage to the decode stage.
  typedef struct packed {
    logic [31:0] win;   // newest byte in the low byte
    logic [38:0] prod;  // float significand times the scale
    logic [1:0]  fmt;
    logic [1:0]  wid;
    logic        last;
  } apsu_item_t;

endpackage

/* src/apsu_in_if.sv */
// Byte stream channel.
interface apsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_data;

  modport source (output valid, output byte_in, output end_of_data, input ready);
  modport sink (input valid, input byte_in, input end_of_data, output ready);
endinterface

/* src/apsu_out_if.sv */
// Sample stream channel.
interface apsu_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] sample;
  logic              final_res;

  modport source (output valid, output sample, output final_res, input ready);
  modport sink (input valid, input sample, input final_res, output ready);
endinterface

/* src/apsu_gather.sv */
module apsu_gather import apsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  apsu_in_if.sink               byte_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output apsu_item_t            item_o,
  output logic                  item_valid_o,
  input  logic                  item_ready_i
);

  logic [1:0]  fmt_q, wid_q;
  logic [1:0]  held_q, held_d;
  logic [23:0] gath_q, gath_d;
  logic        item_valid_q, item_valid_d;
  apsu_item_t  item_q, item_d;
  logic        accept, unsup, complete;
  logic [23:0] sig;

  // A byte is taken whenever the stage register is free or drains this cycle.
  assign byte_i.ready = !item_valid_q || item_ready_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // Format and width combinations that produce no samples.
  always_comb begin
    unique case (fmt_q)
      FMT_BIG, FMT_LITTLE: unsup = 1'b0;
      FMT_FLOAT:           unsup = (wid_q != WID_32);
      default:             unsup = 1'b1;
    endcase
  end

  assign complete = !unsup && (held_q >= wid_q);

  // Float significand with the hidden bit; the first byte is least significant.
  // Subnormals always decode to zero, so the hidden bit may stay set.
  assign sig = {1'b1, gath_q[6:0], gath_q[15:8], gath_q[23:16]};

  // Gathering state and the hand-off to the decode stage.
  always_comb begin
    held_d       = held_q;
    gath_d       = gath_q;
    item_valid_d = item_valid_q && !item_ready_i;
    item_d       = item_q;
    if (accept) begin
      if (unsup || complete) begin
        held_d = '0;
        gath_d = '0;
      end else begin
        gath_d = {gath_q[15:0], byte_i.byte_in};
        held_d = byte_i.end_of_data ? 2'd0 : held_q + 2'd1;
      end
      if (complete) begin
        item_valid_d = 1'b1;
        item_d.win   = {gath_q, byte_i.byte_in};
        item_d.prod  = {15'd0, sig} * {24'd0, FLOAT_SCALE};
        item_d.fmt   = fmt_q;
        item_d.wid   = wid_q;
        item_d.last  = byte_i.end_of_data;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_BIG;
      wid_q        <= WID_16;
      held_q       <= '0;
      gath_q       <= '0;
      item_valid_q <= 1'b0;
    end else begin
      held_q       <= held_d;
      gath_q       <= gath_d;
      item_valid_q <= item_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FORMAT: fmt_q <= cfg_data_i;
          REG_WIDTH:  wid_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o       = item_q;
  assign item_valid_o = item_valid_q;

endmodule

/* src/apsu_decode.sv */
module apsu_decode import apsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  apsu_item_t item_i,
  input  logic       item_valid_i,
  output logic       item_ready_o,
  apsu_out_if.source sample_o
);

  logic        out_valid_q;
  logic [15:0] sample_q, sample_d;
  logic        final_q;
  logic [31:0] win;
  logic        sgn, man_nz, hi, guard, sticky, inc;
  logic [7:0]  ex, shamt;
  logic [23:0] q;
  logic [24:0] qr, m;
  logic [15:0] mag, float_s;

  assign win          = item_i.win;
  assign item_ready_o = !out_valid_q || sample_o.ready;

  // Float fields; the newest byte holds the sign and the top exponent bits.
  assign sgn    = win[7];
  assign ex     = {win[6:0], win[15]};
  assign man_nz = |{win[14:8], win[23:16], win[31:24]};

  // Round the scaled significand to 24 bits, ties to even.
  always_comb begin
    hi = item_i.prod[38];
    if (hi) begin
      q      = item_i.prod[38:15];
      guard  = item_i.prod[14];
      sticky = |item_i.prod[13:0];
    end else begin
      q      = item_i.prod[37:14];
      guard  = item_i.prod[13];
      sticky = |item_i.prod[12:0];
    end
    inc = guard && (sticky || q[0]);
    qr  = {1'b0, q} + {24'd0, inc};
  end

  // Scale down by the exponent, then saturate and apply the sign.
  always_comb begin
    shamt = EXP_SHIFT_BASE - ex - {7'd0, hi};
    m     = qr >> shamt[4:0];
    if (ex >= EXP_SAT) begin
      mag = MAG_SAT;
    end else if (ex < EXP_MIN_LIVE) begin
      mag = '0;
    end else if (m > {9'd0, MAG_SAT}) begin
      mag = MAG_SAT;
    end else begin
      mag = m[15:0];
    end
    if (ex == EXP_SPECIAL && man_nz) begin
      float_s = '0;
    end else if (!sgn) begin
      float_s = (mag > POS_MAX) ? POS_MAX : mag;
    end else begin
      float_s = 16'd0 - mag;
    end
  end

  // Sample selection by width and format.
  always_comb begin
    sample_d = '0;
    if (item_i.wid == WID_8) begin
      sample_d = {{8{~win[7]}}, win[7:0] ^ FLIP_MASK};
    end else begin
      unique case (item_i.fmt)
        FMT_BIG: begin
          unique case (item_i.wid)
            WID_16:  sample_d = win[15:0];
            WID_24:  sample_d = win[23:8];
            default: sample_d = win[31:16];
          endcase
        end
        FMT_LITTLE: sample_d = {win[7:0], win[15:8]};
        FMT_FLOAT:  sample_d = float_s;
        default:    sample_d = '0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      sample_q <= sample_d;
      final_q  <= item_i.last;
    end
  end

  assign sample_o.valid     = out_valid_q;
  assign sample_o.sample    = sample_q;
  assign sample_o.final_res = final_q;

endmodule

/* src/aiff_pcm_sample_unpacker.sv */
// Channel   Dir  Payload                              Transfer
// byte_i    in   byte_in[7:0], end_of_data            valid && ready
// sample_o  out  sample[15:0] signed, final_res       valid && ready
// cfg       in   cfg_idx_i, cfg_data_i[1:0]           cfg_we_i
//
// One byte is taken every cycle while the output side keeps up.
// After its last byte, a sample passes through the gather stage register
// (which also holds the float product) and then the output register.
// byte_i.ready falls only when both the stage and the output register are full.
// Reset is asynchronous and clears all control state at once; there is no clearing pass.
module aiff_pcm_sample_unpacker import apsu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  apsu_in_if.sink               byte_i,
  apsu_out_if.source            sample_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  apsu_item_t item;
  logic       item_valid, item_ready;

  // Byte gathering, configuration and the stage register.
  apsu_gather u_gather (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Sample decode and the output register.
  apsu_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .sample_o     (sample_o)
  );

endmodule

/* src/apsu_checker.sv */
`include "aiff_pcm_sample_unpacker_assert.svh"

module apsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] sample_i,
  input logic        final_res_i
);

  // A stalled sample stays offered.
  `APSU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "sample dropped while stalled")

  // A stalled sample keeps its payload.
  `APSU_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(sample_i) && $stable(final_res_i), "sample changed while stalled")

  // The input side only stalls when a sample is waiting at a stalled output.
  `APSU_ASSERT_NOW(a_in_stall, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output backpressure")

  // Reset empties the output register.
  `APSU_ASSERT_AFTER_RST(a_rst_empty, clk_i, rst_ni, !out_valid_i, "sample offered right after reset")

  // A byte offered while no sample waits at the output is taken.
  `APSU_ASSERT_NOW(a_in_take, clk_i, rst_ni, in_valid_i && !out_valid_i, in_ready_i, "byte refused while the output is empty")

endmodule

bind aiff_pcm_sample_unpacker apsu_checker u_apsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (byte_i.valid),
  .in_ready_i  (byte_i.ready),
  .out_valid_i (sample_o.valid),
  .out_ready_i (sample_o.ready),
  .sample_i    (sample_o.sample),
  .final_res_i (sample_o.final_res)
);

/* sim/aiff_pcm_sample_unpacker_tb.sv */
module aiff_pcm_sample_unpacker_tb;
  import apsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Format code that the block must reject.
  localparam logic [1:0] FMT_UNSUPPORTED = 2'd3;

  localparam int RANDOM_BYTES  = 1000;
  localparam int CALM_BYTES    = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               final_res;
  } sample_rec_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  apsu_in_if  byte_ch ();
  apsu_out_if sample_ch ();

  aiff_pcm_sample_unpacker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_ch),
    .sample_o   (sample_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Decoder shadow state and the samples it still waits for.
  logic [1:0]  cur_fmt;
  logic [1:0]  cur_wid;
  logic [1:0]  held;
  logic [23:0] gathered;
  sample_rec_t pending_samples[$];
  sample_rec_t oldest;

  bit src_idle_on;
  bit snk_idle_on;
  int sink_hold_left;
  int sink_idle_left;
  int quiet_cycles;
  int errors;
  int n_bytes;
  int n_supported;
  int n_checked;
  int n_final;
  int n_float;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Scales IEEE single bits by 32767, rounds the product to 24 bits, truncates
  // and saturates to a 16-bit sample. NaN gives zero.
  function automatic logic [15:0] scale_float(input logic [31:0] bits);
    logic [63:0] mant;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] mag;
    logic [16:0] neg;
    int e2;
    int len;
    int sh;
    if (bits[30:23] == 8'hFF) begin
      if (bits[22:0] != 23'd0) return 16'd0;
      mag = 64'd32768;
    end else begin
      mant = {41'd0, bits[22:0]};
      if (bits[30:23] == 8'd0) begin
        e2 = -149;
      end else begin
        mant[23] = 1'b1;
        e2 = int'(bits[30:23]) - 150;
      end
      prod = mant * 64'd32767;
      len = 0;
      while (len < 64 && (prod >> len) != 64'd0) len++;
      // Round to single precision, ties to even.
      if (len > 24) begin
        sh = len - 24;
        q = prod >> sh;
        rem = prod & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        prod = q << sh;
      end
      if (prod == 64'd0) begin
        mag = 64'd0;
      end else if (e2 >= 0) begin
        if (e2 >= 16 || (prod << e2) > 64'd32768) mag = 64'd32768;
        else mag = prod << e2;
      end else begin
        mag = (-e2 >= 64) ? 64'd0 : (prod >> -e2);
        if (mag > 64'd32768) mag = 64'd32768;
      end
    end
    if (!bits[31]) return (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
    neg = 17'h10000 - mag[16:0];
    return neg[15:0];
  endfunction

  // Applies one accepted byte to the shadow state and queues any sample it completes.
  function automatic void decode_byte(input logic [7:0] b, input logic eod);
    logic [31:0] win;
    logic [31:0] fbits;
    logic [15:0] s;
    sample_rec_t rec;
    int shift;
    n_bytes++;
    if (cur_fmt == FMT_UNSUPPORTED || (cur_fmt == FMT_FLOAT && cur_wid != WID_32)) begin
      held = 2'd0;
      gathered = 24'd0;
      return;
    end
    n_supported++;
    if (held < cur_wid) begin
      gathered = {gathered[15:0], b};
      held = eod ? 2'd0 : held + 2'd1;
      return;
    end
    win = {gathered, b};
    if (cur_wid == WID_8) begin
      s = {{8{~b[7]}}, ~b[7], b[6:0]};
    end else if (cur_fmt == FMT_BIG) begin
      shift = 8 * (int'(cur_wid) - 1);
      s = 16'(win >> shift);
    end else if (cur_fmt == FMT_LITTLE) begin
      s = {win[7:0], win[15:8]};
    end else begin
      fbits = {win[7:0], win[15:8], win[23:16], win[31:24]};
      s = scale_float(fbits);
      n_float++;
    end
    held = 2'd0;
    gathered = 24'd0;
    rec.sample = s;
    rec.final_res = eod;
    pending_samples.push_back(rec);
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Random single-precision bits, weighted toward exponents that land inside
  // the 16-bit range, with zeros, subnormals, infinities and NaNs mixed in.
  function automatic logic [31:0] rand_float();
    logic [7:0]  ex;
    logic [31:0] man;
    case ($urandom_range(0, 15))
      0:       ex = 8'h00;
      1:       ex = 8'hFF;
      2, 3:    ex = 8'($urandom_range(0, 255));
      default: ex = 8'($urandom_range(108, 130));
    endcase
    man = $urandom;
    if ($urandom_range(0, 7) == 0) man = 32'd0;
    return {1'($urandom_range(0, 1)), ex, man[22:0]};
  endfunction

  // Offers one byte, optionally after an idle burst, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic eod);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.byte_in <= b;
    byte_ch.end_of_data <= eod;
    do @(posedge clk_i); while (!byte_ch.ready);
    decode_byte(b, eod);
  endtask

  // Sends the n low bytes of raw, most significant first. End of data goes on
  // byte eod_at, which also ends the sequence; -1 means none.
  task automatic send_bytes(input logic [31:0] raw, input int n, input int eod_at);
    for (int i = 0; i < n; i++) begin
      send_byte(raw[8*(n-1-i) +: 8], i == eod_at);
      if (i == eod_at) break;
    end
  endtask

  // Stops offering bytes until every expected sample has been taken.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic set_mode(input logic [1:0] fmt, input logic [1:0] wid);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_FORMAT;
    cfg_data_i <= fmt;
    @(posedge clk_i);
    cfg_idx_i <= REG_WIDTH;
    cfg_data_i <= wid;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_fmt = fmt;
    cur_wid = wid;
  endtask

  // Reset setting is big-endian 16 bit.
  task automatic test_reset_setting();
    send_bytes(32'h0000_7FFF, 2, -1);
    send_bytes(32'h0000_8000, 2, 1);
  endtask

  // Integer extremes in both byte orders at the 8-, 24- and 32-bit widths.
  task automatic test_integer_modes();
    set_mode(FMT_BIG, WID_8);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    set_mode(FMT_LITTLE, WID_24);
    send_bytes(32'h0012_3456, 3, -1);
    send_bytes(32'h00FF_FFFF, 3, -1);
    set_mode(FMT_BIG, WID_32);
    send_bytes(32'h8000_0001, 4, -1);
    set_mode(FMT_LITTLE, WID_32);
    send_bytes(32'h00FF_7F01, 4, 3);
  endtask

  // NaN, negative infinity, unity, saturating negative and negative zero.
  task automatic test_float_specials();
    set_mode(FMT_FLOAT, WID_32);
    send_bytes(byte_swap(32'h7FC0_0000), 4, -1);
    send_bytes(byte_swap(32'hFF80_0000), 4, -1);
    send_bytes(byte_swap(32'h3F80_0000), 4, -1);
    send_bytes(byte_swap(32'hC000_0000), 4, -1);
    send_bytes(byte_swap(32'h8000_0000), 4, 3);
  endtask

  // Unsupported settings drop bytes and clear a partly gathered sample.
  task automatic test_unsupported();
    set_mode(FMT_BIG, WID_16);
    send_byte(8'hA5, 1'b0);
    set_mode(FMT_FLOAT, WID_16);
    send_bytes(32'h0000_1234, 2, -1);
    set_mode(FMT_UNSUPPORTED, WID_32);
    send_byte(8'hC3, 1'b1);
    set_mode(FMT_BIG, WID_16);
    send_bytes(32'h0000_5A3C, 2, -1);
  endtask

  // End of data on a partial sample drops it; on a full one it is flagged.
  task automatic test_end_of_data();
    set_mode(FMT_BIG, WID_32);
    send_bytes(32'hDEAD_BEEF, 4, 1);
    send_bytes(32'h1357_9BDF, 4, 3);
  endtask

  // Width changes while bytes are held keep them.
  task automatic test_midsample_change();
    set_mode(FMT_BIG, WID_16);
    send_byte(8'h81, 1'b0);
    set_mode(FMT_BIG, WID_32);
    send_bytes(32'h0042_6677, 3, -1);
    send_bytes(32'h0000_99AA, 2, -1);
    set_mode(FMT_BIG, WID_8);
    send_byte(8'h7F, 1'b0);
  endtask

  // The output side holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    set_mode(FMT_BIG, WID_8);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    sink_hold_left = LONG_HOLD;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), 1'b0);
    settle();
  endtask

  // One random sample in the current setting, now and then cut short by end of data.
  task automatic send_random_sample();
    logic [31:0] raw;
    int n;
    int eod_at;
    n = int'(cur_wid) + 1;
    if (cur_fmt == FMT_FLOAT) begin
      raw = byte_swap(rand_float());
    end else begin
      case ($urandom_range(0, 7))
        0:       raw = 32'h0000_0000;
        1:       raw = 32'hFFFF_FFFF;
        default: raw = $urandom;
      endcase
    end
    eod_at = ($urandom_range(0, 29) == 0) ? $urandom_range(0, n - 1) : -1;
    send_bytes(raw, n, eod_at);
  endtask

  // Random phases over changing settings; the last stretch runs without idling.
  task automatic test_random_stream();
    logic [1:0] fmt;
    logic [1:0] wid;
    int phase;
    int count;
    phase = 0;
    while (n_supported < RANDOM_BYTES) begin
      case (phase)
        0: begin fmt = FMT_BIG;    wid = WID_8;  end
        1: begin fmt = FMT_LITTLE; wid = WID_32; end
        2: begin fmt = FMT_FLOAT;  wid = WID_32; end
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            fmt = ($urandom_range(0, 1) == 0) ? FMT_UNSUPPORTED : FMT_FLOAT;
            wid = (fmt == FMT_FLOAT) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
          end else begin
            fmt = 2'($urandom_range(0, 2));
            wid = (fmt == FMT_FLOAT) ? WID_32 : 2'($urandom_range(0, 3));
          end
        end
      endcase
      if (n_supported >= RANDOM_BYTES - CALM_BYTES) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
      end
      set_mode(fmt, wid);
      if (fmt == FMT_UNSUPPORTED || (fmt == FMT_FLOAT && wid != WID_32)) begin
        count = $urandom_range(2, 6);
        for (int i = 0; i < count; i++)
          send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        count = $urandom_range(6, 30);
        for (int i = 0; i < count; i++) begin
          send_random_sample();
          // Occasionally the sender waits until everything has drained.
          if ($urandom_range(0, 39) == 0) settle();
        end
        // A stray byte leaves a sample half gathered across the next setting.
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom), 1'b0);
      end
      phase++;
    end
  endtask

  // Output ready: long hold-offs, random idle bursts, otherwise ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_ch.ready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      sample_ch.ready <= 1'b0;
      sink_hold_left--;
    end else if (sink_idle_left > 0) begin
      sample_ch.ready <= 1'b0;
      sink_idle_left--;
    end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
      sample_ch.ready <= 1'b0;
      sink_idle_left = $urandom_range(1, 16) - 1;
    end else begin
      sample_ch.ready <= 1'b1;
    end
  end

  // Compare every sample transfer with the oldest expected sample.
  always @(posedge clk_i) begin
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, got %0d final %0b",
                 $time, sample_ch.sample, sample_ch.final_res);
        errors++;
      end else begin
        oldest = pending_samples.pop_front();
        n_checked++;
        if (oldest.final_res) n_final++;
        if (oldest.sample !== sample_ch.sample) begin
          $display("%0t: sample mismatch: expected %0d, got %0d",
                   $time, oldest.sample, sample_ch.sample);
          errors++;
        end
        if (oldest.final_res !== sample_ch.final_res) begin
          $display("%0t: final_res mismatch: expected %0b, got %0b",
                   $time, oldest.final_res, sample_ch.final_res);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                   $time, quiet_cycles, pending_samples.size());
          $display("[aiff_pcm_sample_unpacker] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FORMAT;
    cfg_data_i = '0;
    byte_ch.valid = 1'b0;
    byte_ch.byte_in = 8'h00;
    byte_ch.end_of_data = 1'b0;
    sample_ch.ready = 1'b0;
    cur_fmt = FMT_BIG;
    cur_wid = WID_16;
    held = 2'd0;
    gathered = 24'd0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    sink_hold_left = 0;
    sink_idle_left = 0;
    quiet_cycles = 0;
    errors = 0;
    n_bytes = 0;
    n_supported = 0;
    n_checked = 0;
    n_final = 0;
    n_float = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_setting();
    test_integer_modes();
    test_float_specials();
    test_unsupported();
    test_end_of_data();
    test_midsample_change();
    test_backpressure();
    test_random_stream();
    settle();

    $display("Sent %0d bytes (%0d in supported settings); checked %0d samples, %0d float,",
             n_bytes, n_supported, n_checked, n_float);
    $display("%0d at end of data, over all widths, both byte orders, float and rejected settings.",
             n_final);
    if (errors == 0) begin
      $display("[aiff_pcm_sample_unpacker] OK");
    end else begin
      $display("[aiff_pcm_sample_unpacker] ERROR");
    end
    $finish;
  end

endmodule

/* aiff_pcm_sample_unpacker.f */
+incdir+src
src/apsu_pkg.sv
src/apsu_in_if.sv
src/apsu_out_if.sv
src/apsu_gather.sv
src/apsu_decode.sv
src/aiff_pcm_sample_unpacker.sv
src/apsu_checker.sv
sim/aiff_pcm_sample_unpacker_tb.sv
